### rtl/rsaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsaf_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int WIN_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = 40;

  // Shared divider geometry.
  localparam int DVD_W = 64;
  localparam int DVS_W = 32;
  localparam int CNT_W = $clog2(DVD_W);

  // Scaling and mode constants.
  localparam logic [26:0] IF_SCALE   = 27'd100000000;
  localparam logic [29:0] DUTY_SCALE = 30'd1000000000;
  localparam logic [15:0] RPM_SCALE  = 16'd60000;
  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_AVG   = 2'd2,
    REG_IF    = 2'd3
  } reg_idx_t;

  // Measurement modes.
  typedef enum logic [3:0] {
    MODE_FREQ    = 4'd0,
    MODE_FREQ_IF = 4'd1,
    MODE_PER     = 4'd2,
    MODE_HIGH    = 4'd3,
    MODE_LOW     = 4'd4,
    MODE_DUTY    = 4'd5,
    MODE_RPM     = 4'd6,
    MODE_MAX     = 4'd7,
    MODE_MIN     = 4'd8,
    MODE_DEV     = 4'd9
  } mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RAW, S_DDIV, S_SCALE, S_SDIV,
    S_RD, S_SUM, S_AV, S_ADIV, S_CMP, S_OUT
  } state_t;

  // Divisor 10^si with si clamped to 1..8.
  function automatic logic [26:0] pow10(input logic [3:0] si);
    logic [26:0] r;
    begin
      case (si)
        4'd0, 4'd1: r = 27'd10;
        4'd2:       r = 27'd100;
        4'd3:       r = 27'd1000;
        4'd4:       r = 27'd10000;
        4'd5:       r = 27'd100000;
        4'd6:       r = 27'd1000000;
        4'd7:       r = 27'd10000000;
        default:    r = 27'd100000000;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/rsaf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rsaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/rsaf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rsaf_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rsaf_pkg::DVD_W-1:0]   dividend,
  input  wire logic [rsaf_pkg::DVS_W-1:0]   divisor,
  output logic                              busy,
  output logic                              done,
  output logic      [rsaf_pkg::DVD_W-1:0]   quotient
);

  logic [rsaf_pkg::DVS_W:0]     rem;
  logic [rsaf_pkg::DVS_W-1:0]   dvs;
  logic [rsaf_pkg::CNT_W-1:0]   cnt;
  logic [rsaf_pkg::DVS_W:0]     rem_sh;
  logic [rsaf_pkg::DVS_W:0]     rem_sub;
  logic                         take;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem[rsaf_pkg::DVS_W-1:0], quotient[rsaf_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    take    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rsaf_pkg::CNT_W'(rsaf_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register turns into the quotient one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? rem_sub : rem_sh;
      quotient <= {quotient[rsaf_pkg::DVD_W-2:0], take};
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

### rtl/result_scale_average_filter.sv
`timescale 1ns / 1ps
// Each accepted item takes a scaling division, plus an averaging division when the
// window is longer than one; duty-cycle mode adds its own division when both widths
// are nonzero. Each division runs on the single shared restoring divider (one bit
// per cycle). Only one item is in flight at a time, and a result that waits for
// the output holds the input off.
// Reset: synchronous, restores register defaults and empties the ring at once.
`default_nettype none
module result_scale_average_filter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // measured[63:0], highest[127:64], lowest[191:128], deviation[255:192],
  // high_width[286:256], low_width[317:287], zero fill [319:318]
  input  wire logic [319:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // display_value[31:0]
  output logic      [31:0]  m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  // Configuration registers.
  logic [3:0]         mode;
  logic [3:0]         scale_index;
  logic [7:0]         average_count;
  logic signed [31:0] if_offset;

  // Latched item fields.
  logic [63:0] measured, highest, lowest, deviation;
  logic [30:0] high_width, low_width;

  rsaf_pkg::state_t state, state_next;

  logic [63:0]  prod_if, prod_rpm, prod_duty;
  logic [63:0]  raw;
  logic [31:0]  res;
  logic         neg;
  logic signed [rsaf_pkg::SUM_W:0]   av;

  // Filter state.
  logic [rsaf_pkg::RING_DEPTH-1:0]   valid;
  logic [31:0]                       preset_val;
  logic signed [rsaf_pkg::SUM_W-1:0] running_sum;
  logic [rsaf_pkg::PTR_W-1:0]        ring_pointer;

  logic [rsaf_pkg::WIN_W-1:0] n;
  logic [rsaf_pkg::PTR_W-1:0] p_eff;
  logic [rsaf_pkg::PTR_W-1:0] p_inc;
  logic [31:0]                ram_rdata, old_val;
  logic                       ram_we;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;

  logic [26:0] scale_div;
  logic [31:0] hl_sum;
  logic [63:0] mag;
  logic [31:0] q_sat;
  logic signed [rsaf_pkg::SUM_W:0]   t_sum;
  logic signed [rsaf_pkg::SUM_W+1:0] av_16, top, bot, res_x;
  logic                              outside;
  logic signed [rsaf_pkg::SUM_W:0]   preset_sum;

  // Window length clamped to 1..RING_DEPTH.
  always_comb begin
    if (average_count == 8'd0) begin
      n = rsaf_pkg::WIN_W'(1);
    end else if (32'(average_count) > rsaf_pkg::RING_DEPTH) begin
      n = rsaf_pkg::WIN_W'(rsaf_pkg::RING_DEPTH);
    end else begin
      n = rsaf_pkg::WIN_W'(average_count);
    end
  end

  // Ring slot in use and the slot after it.
  always_comb begin
    p_eff = (rsaf_pkg::WIN_W'(ring_pointer) >= n) ? '0 : ring_pointer;
    p_inc = ((rsaf_pkg::WIN_W'(p_eff) + 1'b1) >= n) ? '0 : p_eff + 1'b1;
  end

  // Arithmetic around the shared divider.
  always_comb begin
    scale_div  = rsaf_pkg::pow10(scale_index);
    hl_sum     = {1'b0, high_width} + {1'b0, low_width};
    mag        = raw[63] ? (64'd0 - raw) : raw;
    q_sat      = (div_q > 64'(rsaf_pkg::SAT_MAX)) ? rsaf_pkg::SAT_MAX : div_q[31:0];
    t_sum      = (rsaf_pkg::SUM_W+1)'(running_sum) + $signed({1'b0, n[rsaf_pkg::WIN_W-1:1]});
    old_val    = valid[p_eff] ? ram_rdata : preset_val;
    av_16      = av[rsaf_pkg::SUM_W] ? -((rsaf_pkg::SUM_W+2)'(-av) >>> 4)
                                     : ((rsaf_pkg::SUM_W+2)'(av) >>> 4);
    top        = (rsaf_pkg::SUM_W+2)'(av) + av_16;
    bot        = (rsaf_pkg::SUM_W+2)'(av) - av_16;
    res_x      = (rsaf_pkg::SUM_W+2)'($signed(res));
    outside    = (res_x > top) || (res_x < bot);
    preset_sum = (rsaf_pkg::SUM_W+1)'($signed(res) * $signed({1'b0, n}));
  end

  // Next state and divider requests.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = mag + 64'(scale_div >> 1);
    div_dvs    = 32'(scale_div);
    ram_we     = 1'b0;
    case (state)
      rsaf_pkg::S_IDLE:  if (s_tvalid) state_next = rsaf_pkg::S_MUL;
      rsaf_pkg::S_MUL:   state_next = rsaf_pkg::S_RAW;
      rsaf_pkg::S_RAW: begin
        if (mode == rsaf_pkg::MODE_DUTY && high_width != '0 && low_width != '0) begin
          div_start  = 1'b1;
          div_dvd    = prod_duty + 64'(hl_sum >> 1);
          div_dvs    = hl_sum;
          state_next = rsaf_pkg::S_DDIV;
        end else begin
          state_next = rsaf_pkg::S_SCALE;
        end
      end
      rsaf_pkg::S_DDIV:  if (div_done) state_next = rsaf_pkg::S_SCALE;
      rsaf_pkg::S_SCALE: begin
        div_start  = 1'b1;
        state_next = rsaf_pkg::S_SDIV;
      end
      rsaf_pkg::S_SDIV: begin
        if (div_done) begin
          state_next = (n > rsaf_pkg::WIN_W'(1)) ? rsaf_pkg::S_RD : rsaf_pkg::S_OUT;
        end
      end
      rsaf_pkg::S_RD:    state_next = rsaf_pkg::S_SUM;
      rsaf_pkg::S_SUM: begin
        ram_we     = 1'b1;
        state_next = rsaf_pkg::S_AV;
      end
      rsaf_pkg::S_AV: begin
        div_start  = 1'b1;
        div_dvd    = 64'(t_sum[rsaf_pkg::SUM_W] ? -t_sum : t_sum);
        div_dvs    = 32'(n);
        state_next = rsaf_pkg::S_ADIV;
      end
      rsaf_pkg::S_ADIV:  if (div_done) state_next = rsaf_pkg::S_CMP;
      rsaf_pkg::S_CMP:   state_next = rsaf_pkg::S_OUT;
      rsaf_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) state_next = rsaf_pkg::S_IDLE;
      end
      default:           state_next = rsaf_pkg::S_IDLE;
    endcase
  end

  assign s_tready = (state == rsaf_pkg::S_IDLE);

  // Control state, configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rsaf_pkg::S_IDLE;
      m_tvalid      <= 1'b0;
      mode          <= 4'd0;
      scale_index   <= 4'd1;
      average_count <= 8'd1;
      if_offset     <= '0;
      valid         <= '0;
      preset_val    <= '0;
      running_sum   <= '0;
      ring_pointer  <= '0;
    end else begin
      state <= state_next;
      // A new result replaces the one being taken in the same cycle.
      if (state == rsaf_pkg::S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // Filter update on the item.
      if (state == rsaf_pkg::S_SUM) begin
        running_sum  <= running_sum - rsaf_pkg::SUM_W'($signed(old_val))
                        + rsaf_pkg::SUM_W'($signed(res));
        valid[p_eff] <= 1'b1;
        ring_pointer <= p_inc;
      end
      if (state == rsaf_pkg::S_CMP && outside) begin
        valid        <= '0;
        preset_val   <= res;
        running_sum  <= rsaf_pkg::SUM_W'(preset_sum);
        ring_pointer <= '0;
      end
      // Register writes; mode and window writes empty the filter.
      if (cfg_we) begin
        case (cfg_index)
          rsaf_pkg::REG_MODE:  mode          <= cfg_data[3:0];
          rsaf_pkg::REG_SCALE: scale_index   <= cfg_data[3:0];
          rsaf_pkg::REG_AVG:   average_count <= cfg_data[7:0];
          rsaf_pkg::REG_IF:    if_offset     <= $signed(cfg_data);
          default: ;
        endcase
        if (cfg_index == rsaf_pkg::REG_MODE || cfg_index == rsaf_pkg::REG_AVG) begin
          valid        <= '0;
          preset_val   <= '0;
          running_sum  <= '0;
          ring_pointer <= '0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == rsaf_pkg::S_IDLE && s_tvalid) begin
      measured   <= s_tdata[63:0];
      highest    <= s_tdata[127:64];
      lowest     <= s_tdata[191:128];
      deviation  <= s_tdata[255:192];
      high_width <= s_tdata[286:256];
      low_width  <= s_tdata[317:287];
    end
    if (state == rsaf_pkg::S_MUL) begin
      prod_if   <= 64'(if_offset * $signed({1'b0, rsaf_pkg::IF_SCALE}));
      prod_rpm  <= measured * 64'(rsaf_pkg::RPM_SCALE);
      prod_duty <= 64'(high_width) * 64'(rsaf_pkg::DUTY_SCALE);
    end
    if (state == rsaf_pkg::S_RAW) begin
      case (mode)
        rsaf_pkg::MODE_FREQ, rsaf_pkg::MODE_PER,
        rsaf_pkg::MODE_HIGH, rsaf_pkg::MODE_LOW: raw <= measured;
        rsaf_pkg::MODE_FREQ_IF: raw <= measured + prod_if;
        rsaf_pkg::MODE_RPM:  raw <= prod_rpm;
        rsaf_pkg::MODE_MAX:  raw <= highest;
        rsaf_pkg::MODE_MIN:  raw <= lowest;
        rsaf_pkg::MODE_DEV:  raw <= deviation;
        default:             raw <= '0;
      endcase
    end
    if (state == rsaf_pkg::S_DDIV && div_done) begin
      raw <= div_q;
    end
    if (state == rsaf_pkg::S_SCALE) begin
      neg <= raw[63];
    end
    if (state == rsaf_pkg::S_SDIV && div_done) begin
      res <= neg ? (32'd0 - q_sat) : q_sat;
    end
    if (state == rsaf_pkg::S_AV) begin
      neg <= t_sum[rsaf_pkg::SUM_W];
    end
    if (state == rsaf_pkg::S_ADIV && div_done) begin
      av <= neg ? -$signed((rsaf_pkg::SUM_W+1)'(div_q))
                :  $signed((rsaf_pkg::SUM_W+1)'(div_q));
    end
    if (state == rsaf_pkg::S_CMP && !outside) begin
      res <= av[31:0];
    end
    if (state == rsaf_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= res;
    end
  end

  rsaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  rsaf_ram #(
    .WIDTH (32),
    .DEPTH (rsaf_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_eff),
    .wdata (res),
    .raddr (p_eff),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    rsaf_pkg::WIN_W'(ring_pointer) < n)
    else $error("ring pointer outside the window");
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider requested while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == rsaf_pkg::S_DDIV || state == rsaf_pkg::S_SDIV ||
                  state == rsaf_pkg::S_ADIV))
    else $error("division finished outside a wait state");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // measured, highest, lowest, deviation, high_width, low_width, zero fill
  logic [319:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // display_value
  logic [31:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  result_scale_average_filter u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic signed [63:0] measured;
    logic signed [63:0] highest;
    logic signed [63:0] lowest;
    logic signed [63:0] deviation;
    logic [30:0]        high_width;
    logic [30:0]        low_width;
  } measurement_t;

  // Predictor copy of the registers and filter state.
  logic [3:0]         cur_mode;
  logic [3:0]         cur_scale;
  logic [7:0]         cur_avg;
  logic signed [63:0] cur_if;
  logic signed [31:0] ring [rsaf_pkg::RING_DEPTH];
  logic signed [63:0] ring_sum;
  int unsigned        ring_ptr;

  logic [31:0] expected_display [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycle = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;

  function automatic int unsigned window_len();
    if (cur_avg < 1) return 1;
    if (cur_avg > rsaf_pkg::RING_DEPTH) return rsaf_pkg::RING_DEPTH;
    return cur_avg;
  endfunction

  function automatic void clear_filter(logic signed [31:0] v);
    for (int i = 0; i < rsaf_pkg::RING_DEPTH; i++) ring[i] = v;
    ring_ptr = 0;
    ring_sum = 64'(v) * 64'(window_len());
  endfunction

  // Raw selection, scaling with rounding on the magnitude, saturation, filter.
  function automatic logic [31:0] predict_display(measurement_t m);
    logic [63:0]        raw, mag, q, hi, lo, s;
    logic signed [63:0] av, top, bot;
    logic signed [31:0] res;
    logic               neg;
    int unsigned        n, p, si;
    hi = 64'(m.high_width);
    lo = 64'(m.low_width);
    raw = '0;
    case (cur_mode)
      rsaf_pkg::MODE_FREQ, rsaf_pkg::MODE_PER,
      rsaf_pkg::MODE_HIGH, rsaf_pkg::MODE_LOW: raw = m.measured;
      rsaf_pkg::MODE_FREQ_IF: raw = m.measured + cur_if * 64'd100000000;
      rsaf_pkg::MODE_DUTY: if (hi != 0 && lo != 0)
                   raw = (hi * 64'd1000000000 + (hi + lo) / 2) / (hi + lo);
      rsaf_pkg::MODE_RPM:  raw = m.measured * 64'd60000;
      rsaf_pkg::MODE_MAX:  raw = m.highest;
      rsaf_pkg::MODE_MIN:  raw = m.lowest;
      rsaf_pkg::MODE_DEV:  raw = m.deviation;
      default:   raw = '0;
    endcase
    si = cur_scale;
    if (si < 1) si = 1;
    if (si > 8) si = 8;
    s = 1;
    for (int i = 0; i < si; i++) s = s * 10;
    neg = raw[63];
    mag = neg ? -raw : raw;
    q = (mag + s / 2) / s;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    res = neg ? -$signed(q[31:0]) : $signed(q[31:0]);
    n = window_len();
    if (n > 1) begin
      p = ring_ptr;
      if (p >= n) p = 0;
      ring_sum = ring_sum - 64'(ring[p]) + 64'(res);
      ring[p] = res;
      av = (ring_sum + $signed(64'(n / 2))) / $signed(64'(n));
      p++;
      if (p >= n) p = 0;
      ring_ptr = p;
      top = av + av / 16;
      bot = av - av / 16;
      if (64'(res) > top || 64'(res) < bot) clear_filter(res);
      else res = av[31:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 64'($urandom_range(0, 100000000)) * 64'($urandom_range(1, 1000));
      3: return 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 3));
      default: return 64'($urandom_range(900000, 1100000)) * 1000;
    endcase
  endfunction

  function automatic measurement_t rand_meas();
    measurement_t m;
    logic [63:0] base;
    base = rand64();
    m.measured = base;
    m.highest = ($urandom_range(0, 3) == 0) ? rand64() : base + $urandom_range(0, 50000);
    m.lowest = ($urandom_range(0, 3) == 0) ? rand64() : base - $urandom_range(0, 50000);
    m.deviation = rand64();
    case ($urandom_range(0, 3))
      0: m.high_width = 31'($urandom);
      1: m.high_width = 31'($urandom_range(0, 3));
      default: m.high_width = 31'($urandom_range(1, 100000));
    endcase
    case ($urandom_range(0, 3))
      0: m.low_width = 31'($urandom);
      1: m.low_width = 31'($urandom_range(0, 3));
      default: m.low_width = 31'($urandom_range(1, 100000));
    endcase
    return m;
  endfunction

  task automatic write_reg(rsaf_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsaf_pkg::REG_MODE:  begin cur_mode = val[3:0]; clear_filter(0); end
      rsaf_pkg::REG_SCALE: cur_scale = val[3:0];
      rsaf_pkg::REG_AVG:   begin cur_avg = val[7:0]; clear_filter(0); end
      default:   cur_if = 64'($signed(val));
    endcase
  endtask

  // Offer one item, keeping tvalid high across back-to-back items.
  task automatic send_item(measurement_t m, bit allow_gap);
    if (allow_gap && tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, m.low_width, m.high_width, m.deviation, m.lowest,
                m.highest, m.measured};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_display.push_back(predict_display(m));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_display.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      rx_hold <= 399;
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_display.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected display item %h", m_tdata);
      end else begin
        logic [31:0] e;
        e = expected_display.pop_front();
        if (m_tdata !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("display_value mismatch: expected %h got %h", e, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > 2000000) begin
      $display("timeout after %0d cycles", cycle);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  typedef struct {
    measurement_t m;
    bit           has_value;
    logic [31:0]  value;
  } directed_row_t;

  initial begin
    directed_row_t rows [$];
    measurement_t  m;
    cur_mode = rsaf_pkg::MODE_FREQ; cur_scale = 1; cur_avg = 1; cur_if = 0;
    clear_filter(0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under reset settings (frequency, divide by ten).
    m = '{64'd0, 64'd0, 64'd0, 64'd0, 31'd0, 31'd0};
    rows.push_back('{m, 1'b1, 32'd0});
    m.measured = 64'd15;
    rows.push_back('{m, 1'b1, 32'd2});
    m.measured = -64'sd15;
    rows.push_back('{m, 1'b1, -32'sd2});
    m.measured = 64'd14;
    rows.push_back('{m, 1'b1, 32'd1});
    m.measured = 64'h7FFF_FFFF_FFFF_FFFF;
    rows.push_back('{m, 1'b1, 32'h7FFF_FFFF});
    m.measured = 64'h8000_0000_0000_0000;
    rows.push_back('{m, 1'b1, 32'h8000_0001});
    m.measured = 64'hFFFF_FFFF_FFFF_FFFF;
    rows.push_back('{m, 1'b1, 32'd0});
    foreach (rows[i]) begin
      send_item(rows[i].m, 1'b0);
      if (rows[i].has_value && expected_display[$] !== rows[i].value) begin
        mismatches++;
        $display("predictor disagrees with table row %0d", i);
      end
    end
    drain();

    // Every mode, including undefined ones, with pulse-width extremes.
    for (int md = 0; md < 16; md++) begin
      write_reg(rsaf_pkg::REG_MODE, md);
      write_reg(rsaf_pkg::REG_SCALE, (md % 2) ? 0 : 15);
      write_reg(rsaf_pkg::REG_IF, (md == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      m = '{64'd123456789012, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            -64'sd987654321, 31'h7FFF_FFFF, 31'd1};
      send_item(m, 1'b0);
      m.high_width = 0;
      send_item(m, 1'b0);
      drain();
    end

    // Random phases through the register space.
    for (int ph = 0; ph < 24; ph++) begin
      int cnt;
      write_reg(rsaf_pkg::REG_MODE, (ph < 20) ? ph % 10 : $urandom_range(0, 15));
      write_reg(rsaf_pkg::REG_SCALE,
                (ph == 0) ? 8 : (ph == 1) ? 1 : $urandom_range(0, 15));
      write_reg(rsaf_pkg::REG_IF, $urandom);
      write_reg(rsaf_pkg::REG_AVG, (ph == 2) ? 128 : (ph == 3) ? 255 : (ph == 4) ? 0 :
                         (ph == 5) ? 2 : $urandom_range(0, 20));
      tx_idle_en = (ph < 22);
      rx_idle_en = (ph < 22);
      cnt = 70;
      for (int k = 0; k < cnt; k++) begin
        m = rand_meas();
        // Steady readings exercise the averaging path.
        if ($urandom_range(0, 2) != 0) begin
          m.measured = 64'd50000000 + $urandom_range(0, 40000);
          m.highest = m.measured + 100;
          m.lowest = m.measured - 100;
          m.deviation = 64'($signed($urandom_range(0, 2000))) - 1000;
        end
        if (ph == 6 && k == 5) long_hold_req = 1'b1;
        send_item(m, 1'b1);
      end
      drain();
    end

    $display("covered %0d items, %0d results across all modes, scales and windows",
             items_sent, results_seen);
    if (mismatches == 0 && expected_display.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_display.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
